/* design/assert_macros.svh */
// assertion macros included by the top level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
   else $error("assertion failed");
`define ASSERT_NEVER(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
   else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, prop)
`define ASSERT_NEVER(label, expr)
`endif
`endif

/* design/tbo_pkg.sv */
// shared constants and types of the triangle box overlap test
package tbo_pkg;
   localparam int MUL_CHUNK       = 32;
   localparam int HALF_WIDTH      = 31;
   localparam int TOL_WIDTH       = 16;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 32;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_HALF_X    = 4'd0,
      CSR_HALF_Y    = 4'd1,
      CSR_HALF_Z    = 4'd2,
      CSR_TOLERANCE = 4'd3
   } csr_index_type;
endpackage

/* design/tbo_intf.sv */
// channel interfaces: request, response and register write
interface tbo_req_if #(parameter int COORD_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] vertex0_x;
   logic signed [COORD_WIDTH-1:0] vertex0_y;
   logic signed [COORD_WIDTH-1:0] vertex0_z;
   logic signed [COORD_WIDTH-1:0] vertex1_x;
   logic signed [COORD_WIDTH-1:0] vertex1_y;
   logic signed [COORD_WIDTH-1:0] vertex1_z;
   logic signed [COORD_WIDTH-1:0] vertex2_x;
   logic signed [COORD_WIDTH-1:0] vertex2_y;
   logic signed [COORD_WIDTH-1:0] vertex2_z;
   logic signed [COORD_WIDTH-1:0] center_x;
   logic signed [COORD_WIDTH-1:0] center_y;
   logic signed [COORD_WIDTH-1:0] center_z;
   modport source (output valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y,
                   vertex1_z, vertex2_x, vertex2_y, vertex2_z, center_x, center_y,
                   center_z, input ready);
   modport sink (input valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y,
                 vertex1_z, vertex2_x, vertex2_y, vertex2_z, center_x, center_y,
                 center_z, output ready);
endinterface

interface tbo_rsp_if;
   logic valid;
   logic ready;
   logic overlaps;
   modport source (output valid, overlaps, input ready);
   modport sink (input valid, overlaps, output ready);
endinterface

interface tbo_csr_if;
   logic                                    valid;
   logic                                    ready;
   logic [tbo_pkg::CSR_INDEX_WIDTH-1:0]     index;
   logic [tbo_pkg::CSR_DATA_WIDTH-1:0]      data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* design/triangle_box_overlap_test.sv */
// top level: pipelined triangle against box separating axis test
//
//   channel | dir | contents
//   req_if  | in  | three vertices and box center, signed fixed point
//   rsp_if  | out | overlaps flag, one beat per request beat
//   csr_if  | in  | register index and data, always ready
//
// eleven register stages, one request beat per cycle while response beats are taken
// the multiplier pipelines (three stages each) set the depth
// the whole pipe advances together and freezes while a response beat waits
// reset clears valid bits and loads the reset register values
`include "assert_macros.svh"

module triangle_box_overlap_test #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic      clock,
   input  logic      reset,
   tbo_req_if.sink   req_if,
   tbo_rsp_if.source rsp_if,
   tbo_csr_if.sink   csr_if
);
   localparam int HW    = tbo_pkg::HALF_WIDTH + 1;   // half size as signed operand
   localparam int TW    = tbo_pkg::TOL_WIDTH;
   localparam int VW    = COORD_WIDTH + 1;           // vertex relative to center
   localparam int EW    = COORD_WIDTH + 2;           // edge vector
   localparam int NW    = 2 * EW + 1;                // plane normal
   localparam int XW    = (VW > HW + 1 ? VW : HW + 1) + 1;
   localparam int EPW   = EW + VW + 1;
   localparam int ELW   = HW + EW + 2;
   localparam int ECW   = (EPW > ELW ? EPW : ELW) + 1;
   localparam int PDW   = NW + VW + 2;
   localparam int PRW   = HW + NW + 2;
   localparam int PCW   = (PDW > PRW ? PDW : PRW) + 1;
   localparam int STAGES = 11;

   // ---------------------------------------------------------------- registers
   logic [tbo_pkg::HALF_WIDTH-1:0] half_ff [3];
   logic [TW-1:0]                  tol_ff;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            half_ff[k] <= tbo_pkg::HALF_WIDTH'(32768);
         end
         tol_ff <= TW'(1);
      end else if (csr_if.valid) begin
         case (csr_if.index)
            tbo_pkg::CSR_HALF_X:    half_ff[0] <= csr_if.data[tbo_pkg::HALF_WIDTH-1:0];
            tbo_pkg::CSR_HALF_Y:    half_ff[1] <= csr_if.data[tbo_pkg::HALF_WIDTH-1:0];
            tbo_pkg::CSR_HALF_Z:    half_ff[2] <= csr_if.data[tbo_pkg::HALF_WIDTH-1:0];
            tbo_pkg::CSR_TOLERANCE: tol_ff     <= csr_if.data[TW-1:0];
            default: ;   // unknown index, write dropped
         endcase
      end
   end

   logic signed [HW-1:0]  hs [3];
   logic signed [XW-1:0]  ext_lim;
   logic signed [ECW-1:0] eps2;
   logic signed [PCW-1:0] eps3;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         hs[k] = $signed({1'b0, half_ff[k]});
      end
      eps2 = $signed(ECW'(tol_ff) << FRAC_BITS);
      eps3 = $signed(PCW'(tol_ff) << (2 * FRAC_BITS));
   end

   // ---------------------------------------------------------------- pipe control
   logic [STAGES-1:0] vld_ff;
   logic              pipe_en;
   logic              overlap_ff, overlap_in;

   // all stages move together; the output register empties or is taken
   assign pipe_en      = rsp_if.ready || !vld_ff[STAGES-1];
   assign req_if.ready = pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= {vld_ff[STAGES-2:0], req_if.valid};
      end
   end

   // ---------------------------------------------------------------- stage 1: relative vertices
   logic signed [COORD_WIDTH-1:0] in_c [4][3];
   logic signed [VW-1:0]          v1_ff [3][3];
   logic signed [VW-1:0]          v1_in [3][3];

   assign in_c[0][0] = req_if.vertex0_x;
   assign in_c[0][1] = req_if.vertex0_y;
   assign in_c[0][2] = req_if.vertex0_z;
   assign in_c[1][0] = req_if.vertex1_x;
   assign in_c[1][1] = req_if.vertex1_y;
   assign in_c[1][2] = req_if.vertex1_z;
   assign in_c[2][0] = req_if.vertex2_x;
   assign in_c[2][1] = req_if.vertex2_y;
   assign in_c[2][2] = req_if.vertex2_z;
   assign in_c[3][0] = req_if.center_x;
   assign in_c[3][1] = req_if.center_y;
   assign in_c[3][2] = req_if.center_z;

   always_comb begin
      for (int t = 0; t < 3; t++) begin
         for (int k = 0; k < 3; k++) begin
            v1_in[t][k] = VW'(in_c[t][k]) - VW'(in_c[3][k]);
         end
      end
   end

   // ---------------------------------------------------------------- stage 2: edges, extent test
   logic signed [VW-1:0] v2_ff [3][3];
   logic signed [EW-1:0] e2_ff [3][3];
   logic signed [EW-1:0] e2_in [3][3];
   logic                 ext2_ff, ext2_in;

   always_comb begin
      ext2_in = 1'b1;
      for (int t = 0; t < 3; t++) begin
         for (int k = 0; k < 3; k++) begin
            e2_in[t][k] = EW'(v1_ff[(t + 1) % 3][k]) - EW'(v1_ff[t][k]);
         end
      end
      for (int k = 0; k < 3; k++) begin
         ext_lim = XW'(hs[k]) + $signed(XW'(tol_ff));
         // all three beyond one face of the box along this axis
         if ((XW'(v1_ff[0][k]) > ext_lim && XW'(v1_ff[1][k]) > ext_lim &&
              XW'(v1_ff[2][k]) > ext_lim) ||
             (XW'(v1_ff[0][k]) < -ext_lim && XW'(v1_ff[1][k]) < -ext_lim &&
              XW'(v1_ff[2][k]) < -ext_lim)) begin
            ext2_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         v1_ff   <= v1_in;
         v2_ff   <= v1_ff;
         e2_ff   <= e2_in;
         ext2_ff <= ext2_in;
      end
   end

   // ---------------------------------------------------------------- stages 3-5: first products
   logic signed [EW+VW-1:0] pa0 [3][3];
   logic signed [EW+VW-1:0] pa1 [3][3];
   logic signed [EW+VW-1:0] pb0 [3][3];
   logic signed [EW+VW-1:0] pb1 [3][3];
   logic signed [HW+EW-1:0] l0  [3][3];
   logic signed [HW+EW-1:0] l1  [3][3];
   logic signed [2*EW-1:0]  nm0 [3];
   logic signed [2*EW-1:0]  nm1 [3];

   for (genvar t = 0; t < 3; t++) begin : g_edge
      for (genvar a = 0; a < 3; a++) begin : g_axis
         localparam int I  = (a + 1) % 3;
         localparam int J  = (a + 2) % 3;
         localparam int TB = (t + 2) % 3;
         tbo_mul #(.A_WIDTH(EW), .B_WIDTH(VW)) u_pa0 (
            .clock(clock), .en(pipe_en), .a(e2_ff[t][I]), .b(v2_ff[t][J]),
            .product(pa0[t][a]));
         tbo_mul #(.A_WIDTH(EW), .B_WIDTH(VW)) u_pa1 (
            .clock(clock), .en(pipe_en), .a(e2_ff[t][J]), .b(v2_ff[t][I]),
            .product(pa1[t][a]));
         tbo_mul #(.A_WIDTH(EW), .B_WIDTH(VW)) u_pb0 (
            .clock(clock), .en(pipe_en), .a(e2_ff[t][I]), .b(v2_ff[TB][J]),
            .product(pb0[t][a]));
         tbo_mul #(.A_WIDTH(EW), .B_WIDTH(VW)) u_pb1 (
            .clock(clock), .en(pipe_en), .a(e2_ff[t][J]), .b(v2_ff[TB][I]),
            .product(pb1[t][a]));
         tbo_mul #(.A_WIDTH(HW), .B_WIDTH(EW)) u_l0 (
            .clock(clock), .en(pipe_en), .a(hs[I]), .b(e2_ff[t][J]),
            .product(l0[t][a]));
         tbo_mul #(.A_WIDTH(HW), .B_WIDTH(EW)) u_l1 (
            .clock(clock), .en(pipe_en), .a(hs[J]), .b(e2_ff[t][I]),
            .product(l1[t][a]));
      end
   end

   for (genvar a = 0; a < 3; a++) begin : g_normal
      localparam int I = (a + 1) % 3;
      localparam int J = (a + 2) % 3;
      tbo_mul #(.A_WIDTH(EW), .B_WIDTH(EW)) u_n0 (
         .clock(clock), .en(pipe_en), .a(e2_ff[0][I]), .b(e2_ff[1][J]), .product(nm0[a]));
      tbo_mul #(.A_WIDTH(EW), .B_WIDTH(EW)) u_n1 (
         .clock(clock), .en(pipe_en), .a(e2_ff[0][J]), .b(e2_ff[1][I]), .product(nm1[a]));
   end

   // ---------------------------------------------------------------- stage 6: projections, normal
   logic signed [ECW-1:0] p0_ff  [3][3];
   logic signed [ECW-1:0] p1_ff  [3][3];
   logic signed [ECW-1:0] lim_ff [3][3];
   logic signed [ECW-1:0] p0_in  [3][3];
   logic signed [ECW-1:0] p1_in  [3][3];
   logic signed [ECW-1:0] lim_in [3][3];
   logic signed [ECW-1:0] la, lb;
   logic signed [NW-1:0]  n6_ff [3];
   logic signed [NW-1:0]  n6_in [3];

   always_comb begin
      la = '0;
      lb = '0;
      for (int t = 0; t < 3; t++) begin
         for (int a = 0; a < 3; a++) begin
            p0_in[t][a]  = ECW'(pa0[t][a]) - ECW'(pa1[t][a]);
            p1_in[t][a]  = ECW'(pb0[t][a]) - ECW'(pb1[t][a]);
            la           = ECW'(l0[t][a]);
            lb           = ECW'(l1[t][a]);
            lim_in[t][a] = (la < 0 ? -la : la) + (lb < 0 ? -lb : lb) + eps2;
         end
      end
      for (int a = 0; a < 3; a++) begin
         n6_in[a] = NW'(nm0[a]) - NW'(nm1[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         p0_ff  <= p0_in;
         p1_ff  <= p1_in;
         lim_ff <= lim_in;
         n6_ff  <= n6_in;
      end
   end

   // first vertex waits for the normal
   logic [3*VW-1:0]      v0_pack, v0_late;
   logic signed [VW-1:0] v0_6 [3];

   assign v0_pack = {v2_ff[0][2], v2_ff[0][1], v2_ff[0][0]};

   tbo_delay #(.WIDTH(3 * VW), .DEPTH(4)) u_v0_delay (
      .clock(clock), .en(pipe_en), .din(v0_pack), .dout(v0_late));

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         v0_6[k] = $signed(v0_late[k*VW +: VW]);
      end
   end

   // ---------------------------------------------------------------- stage 7: edge axis tests
   logic edge7_ff, edge7_in;

   always_comb begin
      edge7_in = 1'b1;
      for (int t = 0; t < 3; t++) begin
         for (int a = 0; a < 3; a++) begin
            if ((p0_ff[t][a] > lim_ff[t][a] && p1_ff[t][a] > lim_ff[t][a]) ||
                (p0_ff[t][a] < -lim_ff[t][a] && p1_ff[t][a] < -lim_ff[t][a])) begin
               edge7_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         edge7_ff <= edge7_in;
      end
   end

   // ---------------------------------------------------------------- stages 7-9: plane products
   logic signed [NW+VW-1:0] nv [3];
   logic signed [HW+NW-1:0] hn [3];

   for (genvar k = 0; k < 3; k++) begin : g_plane
      tbo_mul #(.A_WIDTH(NW), .B_WIDTH(VW)) u_nv (
         .clock(clock), .en(pipe_en), .a(n6_ff[k]), .b(v0_6[k]), .product(nv[k]));
      tbo_mul #(.A_WIDTH(HW), .B_WIDTH(NW)) u_hn (
         .clock(clock), .en(pipe_en), .a(hs[k]), .b(n6_ff[k]), .product(hn[k]));
   end

   // ---------------------------------------------------------------- stage 10: plane sums
   logic signed [PCW-1:0] d10_ff, d10_in, r10_ff, r10_in, hterm;

   always_comb begin
      d10_in = '0;
      r10_in = eps3;
      hterm  = '0;
      for (int k = 0; k < 3; k++) begin
         d10_in = d10_in - PCW'(nv[k]);
         hterm  = PCW'(hn[k]);
         r10_in = r10_in + (hterm < 0 ? -hterm : hterm);
      end
   end

   logic ext10, edge10;

   tbo_delay #(.WIDTH(1), .DEPTH(8)) u_ext_delay (
      .clock(clock), .en(pipe_en), .din(ext2_ff), .dout(ext10));
   tbo_delay #(.WIDTH(1), .DEPTH(3)) u_edge_delay (
      .clock(clock), .en(pipe_en), .din(edge7_ff), .dout(edge10));

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         d10_ff <= d10_in;
         r10_ff <= r10_in;
      end
   end

   // ---------------------------------------------------------------- stage 11: verdict
   // a degenerate triangle has a zero normal, so the plane test passes by itself
   assign overlap_in = ext10 && edge10 && !(d10_ff > r10_ff || d10_ff < -r10_ff);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         overlap_ff <= overlap_in;
      end
   end

   assign rsp_if.valid    = vld_ff[STAGES-1];
   assign rsp_if.overlaps = overlap_ff;

   // ---------------------------------------------------------------- checks
   `ASSERT_PROP(a_accept_enters, (req_if.valid && req_if.ready) |=> vld_ff[0])
   `ASSERT_PROP(a_stall_freezes, !pipe_en |=> $stable(vld_ff))
   `ASSERT_PROP(a_tol_write, (csr_if.valid && csr_if.index == tbo_pkg::CSR_TOLERANCE) |=> tol_ff == $past(csr_if.data[TW-1:0]))
endmodule

/* design/tbo_mul.sv */
// pipelined signed multiplier built from chunk partial products, three stages
module tbo_mul #(
   parameter int A_WIDTH = 32,
   parameter int B_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [A_WIDTH-1:0]         a,
   input  logic signed [B_WIDTH-1:0]         b,
   output logic signed [A_WIDTH+B_WIDTH-1:0] product
);
   localparam int C  = tbo_pkg::MUL_CHUNK;
   localparam int NA = (A_WIDTH + C - 1) / C;
   localparam int NB = (B_WIDTH + C - 1) / C;
   localparam int PW = A_WIDTH + B_WIDTH;

   logic [A_WIDTH-1:0]   mag_a;
   logic [B_WIDTH-1:0]   mag_b;
   logic [NA*C-1:0]      ua_ff, ua_in;
   logic [NB*C-1:0]      ub_ff, ub_in;
   logic                 neg1_ff, neg1_in, neg2_ff;
   logic [2*C-1:0]       pp_ff [NA][NB];
   logic [2*C-1:0]       pp_in [NA][NB];
   logic [PW-1:0]        acc;
   logic signed [PW-1:0] product_ff, product_in;

   always_comb begin
      mag_a   = a[A_WIDTH-1] ? A_WIDTH'(-a) : a;
      mag_b   = b[B_WIDTH-1] ? B_WIDTH'(-b) : b;
      ua_in   = (NA*C)'(mag_a);
      ub_in   = (NB*C)'(mag_b);
      neg1_in = a[A_WIDTH-1] ^ b[B_WIDTH-1];
   end

   always_comb begin
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            pp_in[i][j] = ua_ff[i*C +: C] * ub_ff[j*C +: C];
         end
      end
   end

   always_comb begin
      acc = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            acc = acc + (PW'(pp_ff[i][j]) << (C * (i + j)));
         end
      end
      product_in = neg2_ff ? -$signed(acc) : $signed(acc);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ua_ff      <= ua_in;
         ub_ff      <= ub_in;
         neg1_ff    <= neg1_in;
         pp_ff      <= pp_in;
         neg2_ff    <= neg1_ff;
         product_ff <= product_in;
      end
   end

   assign product = product_ff;
endmodule

/* design/tbo_delay.sv */
// enabled shift line that carries a payload through DEPTH stages
module tbo_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);
   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];
endmodule
